@@ sv/akf_pkg.sv @@
`default_nettype none
package akf_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned ANGLE_W        = 32;
  localparam int unsigned DT_W           = 16;
  localparam int unsigned NOISE_W        = 32;
  localparam int unsigned IDX_W          = 2;
  localparam int unsigned FRAC_T         = 16;  // shift after a time-step product
  localparam int unsigned FRAC_K         = 24;  // shift after a gain product and fraction bits of a quotient
  localparam int unsigned DIGIT_W        = 4;   // multiplier digit

  localparam logic [NOISE_W-1:0] ANGLE_NOISE_RST   = 32'd16777;
  localparam logic [NOISE_W-1:0] BIAS_NOISE_RST    = 32'd50332;
  localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST = 32'd503316;

  typedef enum logic [IDX_W-1:0] {
    CFG_ANGLE_NOISE   = 2'd0,
    CFG_BIAS_NOISE    = 2'd1,
    CFG_MEASURE_NOISE = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    MDU_MUL = 1'b0,
    MDU_DIV = 1'b1
  } mdu_op_e;

  typedef struct packed {
    logic    start;
    mdu_op_e op;
    logic    sh24;
  } mdu_ctrl_t;

endpackage
`default_nettype wire

@@ sv/akf_if.sv @@
`default_nettype none
interface akf_in_if import akf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] measured_angle;
  logic signed [ANGLE_W-1:0] measured_rate;
  logic        [DT_W-1:0]    time_step;

  modport source (output valid, measured_angle, measured_rate, time_step, input ready);
  modport sink   (input valid, measured_angle, measured_rate, time_step, output ready);
endinterface

interface akf_out_if import akf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] filtered_angle;

  modport source (output valid, filtered_angle, input ready);
  modport sink   (input valid, filtered_angle, output ready);
endinterface
`default_nettype wire

@@ sv/akf_mdu.sv @@
`default_nettype none
module akf_mdu import akf_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  mdu_ctrl_t                              ctrl_i,
  input  logic signed [((DATA_WIDTH > 33) ? DATA_WIDTH : 33) + 1:0] a_i,
  input  logic signed [((DATA_WIDTH > 33) ? DATA_WIDTH : 33) + 1:0] b_i,
  output logic                                   done_o,
  output logic signed [DATA_WIDTH-1:0]           res_o
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned EW = ((W > 33) ? W : 33) + 2;
  localparam int unsigned MW = EW;
  localparam int unsigned ND = (MW + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned BW = ND * DIGIT_W;
  localparam int unsigned PW = MW + BW;
  localparam int unsigned QW = W + FRAC_K;
  localparam int unsigned VW = (PW > QW) ? PW : QW;
  localparam int unsigned CW = $clog2(QW + 1);

  typedef enum logic [4:0] {
    U_IDLE = 5'b00001,
    U_PREP = 5'b00010,
    U_RUN  = 5'b00100,
    U_FIN  = 5'b01000,
    U_SIGN = 5'b10000
  } mdu_state_e;

  mdu_state_e        state_q, state_d;
  logic [CW-1:0]     cnt_q;
  logic              done_q;
  mdu_op_e           op_q;
  logic              sh24_q;
  logic [EW-1:0]     a_q, b_q;
  logic              neg_q, dz_q;
  logic [MW-1:0]     am_q;
  logic [BW-1:0]     bm_q;
  logic [PW-1:0]     prod_q;
  logic [MW-1:0]     rem_q;
  logic [QW-1:0]     quo_q;
  logic [W-1:0]      qmag_q;
  logic signed [W-1:0] res_q;

  logic [EW-1:0]         mag_a, mag_b;
  logic [MW+DIGIT_W-1:0] mul_t;
  logic [MW:0]           rs, diff;
  logic                  dge;
  logic [VW-1:0]         qv;
  logic [W-1:0]          lim;

  assign mag_a = a_q[EW-1] ? (~a_q + {{(EW-1){1'b0}}, 1'b1}) : a_q;
  assign mag_b = b_q[EW-1] ? (~b_q + {{(EW-1){1'b0}}, 1'b1}) : b_q;

  // one digit of the multiplier per cycle, partial sum shifts right
  assign mul_t = {{DIGIT_W{1'b0}}, prod_q[PW-1:BW]}
               + ({{DIGIT_W{1'b0}}, am_q} * {{MW{1'b0}}, bm_q[DIGIT_W-1:0]});

  // restoring division, one quotient bit per cycle
  assign rs   = {rem_q, quo_q[QW-1]};
  assign dge  = rs >= {1'b0, am_q};
  assign diff = rs - {1'b0, am_q};

  assign lim = {1'b0, {(W-1){1'b1}}} + {{(W-1){1'b0}}, neg_q};

  always_comb begin
    if (op_q == MDU_MUL) begin
      if (sh24_q) begin
        qv = VW'(prod_q[PW-1:FRAC_K]) + VW'(prod_q[FRAC_K-1]);
      end else begin
        qv = VW'(prod_q[PW-1:FRAC_T]) + VW'(prod_q[FRAC_T-1]);
      end
    end else begin
      qv = dz_q ? '0 : VW'(quo_q);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      U_IDLE: if (ctrl_i.start) state_d = U_PREP;
      U_PREP: state_d = U_RUN;
      U_RUN:  if (cnt_q == CW'(1)) state_d = U_FIN;
      U_FIN:  state_d = U_SIGN;
      U_SIGN: state_d = U_IDLE;
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == U_SIGN);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      U_IDLE: begin
        if (ctrl_i.start) begin
          op_q   <= ctrl_i.op;
          sh24_q <= ctrl_i.sh24;
          a_q    <= a_i;
          b_q    <= b_i;
        end
      end
      U_PREP: begin
        neg_q <= a_q[EW-1] ^ b_q[EW-1];
        dz_q  <= (mag_b == '0);
        if (op_q == MDU_MUL) begin
          am_q   <= mag_a;
          bm_q   <= BW'(mag_b);
          prod_q <= '0;
          cnt_q  <= CW'(ND);
        end else begin
          am_q  <= mag_b;
          rem_q <= '0;
          quo_q <= {mag_a[W-1:0], {FRAC_K{1'b0}}};
          cnt_q <= CW'(QW);
        end
      end
      U_RUN: begin
        cnt_q <= cnt_q - CW'(1);
        if (op_q == MDU_MUL) begin
          prod_q <= {mul_t, prod_q[BW-1:DIGIT_W]};
          bm_q   <= bm_q >> DIGIT_W;
        end else begin
          rem_q <= dge ? diff[MW-1:0] : rs[MW-1:0];
          quo_q <= {quo_q[QW-2:0], dge};
        end
      end
      U_FIN: begin
        qmag_q <= (qv > VW'(lim)) ? lim : qv[W-1:0];
      end
      U_SIGN: begin
        res_q <= neg_q ? -$signed(qmag_q) : $signed(qmag_q);
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

@@ sv/angle_kalman_filter.sv @@
`default_nettype none
// Two-state tilt filter: fuses an accelerometer angle with a gyro rate, tracks the
// gyro bias and a 2x2 error covariance, and returns one saturated Q16.16 angle per
// input word. Noise terms (Q8.24) are written through the cfg port; the user must
// write them only while idle, as the block itself does not enforce it. One item at
// a time; the time per word is set by the shared serial multiply/divide unit, with
// 10 multiplies and two divides per word, two innovation updates that need no unit
// and the idle state that takes the word. A result that is still waiting holds up
// the last correction step.
// A finished word waits in the output register while the next word is taken in.
module angle_kalman_filter import akf_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  akf_in_if.sink             in_i,
  akf_out_if.source          out_o,
  input  logic               cfg_we_i,
  input  logic [IDX_W-1:0]   cfg_idx_i,
  input  logic [NOISE_W-1:0] cfg_wdata_i
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned EW = ((W > 33) ? W : 33) + 2;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SETUP = 4'b0010,
    S_WAIT  = 4'b0100,
    S_POST  = 4'b1000
  } state_e;

  typedef enum logic [13:0] {
    ST_ANG = 14'h0001,
    ST_T   = 14'h0002,
    ST_IN1 = 14'h0004,
    ST_IN2 = 14'h0008,
    ST_P0  = 14'h0010,
    ST_P3  = 14'h0020,
    ST_K0  = 14'h0040,
    ST_K1  = 14'h0080,
    ST_CA  = 14'h0100,
    ST_CB  = 14'h0200,
    ST_C0  = 14'h0400,
    ST_C1  = 14'h0800,
    ST_C2  = 14'h1000,
    ST_C3  = 14'h2000
  } step_e;

  function automatic logic signed [W-1:0] sat_w(input logic signed [EW-1:0] x);
    logic signed [W-1:0] r;
    if (&x[EW-1:W-1] || ~|x[EW-1:W-1]) begin
      r = x[W-1:0];
    end else begin
      r = x[EW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [ANGLE_W-1:0] sat_out(input logic signed [EW-1:0] x);
    logic signed [ANGLE_W-1:0] r;
    if (&x[EW-1:ANGLE_W-1] || ~|x[EW-1:ANGLE_W-1]) begin
      r = x[ANGLE_W-1:0];
    end else begin
      r = x[EW-1] ? {1'b1, {(ANGLE_W-1){1'b0}}} : {1'b0, {(ANGLE_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [EW-1:0] sx(input logic signed [W-1:0] v);
    return {{(EW-W){v[W-1]}}, v};
  endfunction

  function automatic logic signed [EW-1:0] sx_in(input logic signed [ANGLE_W-1:0] v);
    return {{(EW-ANGLE_W){v[ANGLE_W-1]}}, v};
  endfunction

  function automatic logic signed [EW-1:0] zx_n(input logic [NOISE_W-1:0] v);
    return {{(EW-NOISE_W){1'b0}}, v};
  endfunction

  state_e state_q, state_d;
  step_e  step_q, step_d;
  logic   out_valid_q;
  logic signed [ANGLE_W-1:0] out_data_q;

  logic [NOISE_W-1:0] angle_noise_q, bias_noise_q, measure_noise_q;

  logic signed [ANGLE_W-1:0] ma_q, mr_q;
  logic        [DT_W-1:0]    dt_q;
  logic signed [W-1:0]       ang_q, bias_q;
  logic signed [W-1:0]       p_q [4];
  logic signed [W-1:0]       t_q, inn_q, k0_q, k1_q, y_q, p00_q, p01_q;
  logic signed [EW-1:0]      s_q;

  mdu_ctrl_t            mdu_ctrl;
  logic signed [EW-1:0] mdu_a, mdu_b;
  logic                 mdu_done;
  logic signed [W-1:0]  mdu_res;
  logic                 in_acc, out_free, post_fire, no_unit;
  logic signed [EW-1:0] dt_x;

  assign in_acc    = in_i.valid && in_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign post_fire = (state_q == S_POST) && ((step_q != ST_C3) || out_free);
  assign no_unit   = (step_q == ST_IN1) || (step_q == ST_IN2);
  assign dt_x      = {{(EW-DT_W){1'b0}}, dt_q};

  // operand select for the shared unit
  always_comb begin
    mdu_a         = dt_x;
    mdu_b         = sx(p_q[3]);
    mdu_ctrl.op   = MDU_MUL;
    mdu_ctrl.sh24 = 1'b1;
    unique case (step_q) inside
      ST_ANG: begin
        mdu_b         = sx(sat_w(sx_in(mr_q) - sx(bias_q)));
        mdu_ctrl.sh24 = 1'b0;
      end
      ST_T: mdu_ctrl.sh24 = 1'b0;
      ST_IN1, ST_IN2: mdu_ctrl.sh24 = 1'b0;
      ST_P0: begin
        mdu_b         = sx(inn_q);
        mdu_ctrl.sh24 = 1'b0;
      end
      ST_P3: begin
        mdu_a         = zx_n(bias_noise_q);
        mdu_b         = dt_x;
        mdu_ctrl.sh24 = 1'b0;
      end
      ST_K0: begin
        mdu_a       = sx(p_q[0]);
        mdu_b       = s_q;
        mdu_ctrl.op = MDU_DIV;
      end
      ST_K1: begin
        mdu_a       = sx(p_q[2]);
        mdu_b       = s_q;
        mdu_ctrl.op = MDU_DIV;
      end
      ST_CA: begin
        mdu_a = sx(k0_q);
        mdu_b = sx(y_q);
      end
      ST_CB: begin
        mdu_a = sx(k1_q);
        mdu_b = sx(y_q);
      end
      ST_C0: begin
        mdu_a = sx(k0_q);
        mdu_b = sx(p00_q);
      end
      ST_C1: begin
        mdu_a = sx(k0_q);
        mdu_b = sx(p01_q);
      end
      ST_C2: begin
        mdu_a = sx(k1_q);
        mdu_b = sx(p00_q);
      end
      ST_C3: begin
        mdu_a = sx(k1_q);
        mdu_b = sx(p01_q);
      end
      default: ;
    endcase
    mdu_ctrl.start = (state_q == S_SETUP) && !no_unit;
  end

  akf_mdu #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mdu_ctrl),
    .a_i    (mdu_a),
    .b_i    (mdu_b),
    .done_o (mdu_done),
    .res_o  (mdu_res)
  );

  always_comb begin
    unique case (step_q)
      ST_ANG:  step_d = ST_T;
      ST_T:    step_d = ST_IN1;
      ST_IN1:  step_d = ST_IN2;
      ST_IN2:  step_d = ST_P0;
      ST_P0:   step_d = ST_P3;
      ST_P3:   step_d = ST_K0;
      ST_K0:   step_d = ST_K1;
      ST_K1:   step_d = ST_CA;
      ST_CA:   step_d = ST_CB;
      ST_CB:   step_d = ST_C0;
      ST_C0:   step_d = ST_C1;
      ST_C1:   step_d = ST_C2;
      ST_C2:   step_d = ST_C3;
      ST_C3:   step_d = ST_ANG;
      default: step_d = ST_ANG;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = S_SETUP;
      S_SETUP: state_d = no_unit ? S_POST : S_WAIT;
      S_WAIT:  if (mdu_done) state_d = S_POST;
      S_POST:  if (post_fire) state_d = (step_q == ST_C3) ? S_IDLE : S_SETUP;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      step_q          <= ST_ANG;
      out_valid_q     <= 1'b0;
      angle_noise_q   <= ANGLE_NOISE_RST;
      bias_noise_q    <= BIAS_NOISE_RST;
      measure_noise_q <= MEASURE_NOISE_RST;
      ang_q           <= '0;
      bias_q          <= '0;
      for (int i = 0; i < 4; i++) begin
        p_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        step_q <= ST_ANG;
      end else if (post_fire) begin
        step_q <= step_d;
      end

      if (post_fire && (step_q == ST_C3)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ANGLE_NOISE:   angle_noise_q   <= cfg_wdata_i;
          CFG_BIAS_NOISE:    bias_noise_q    <= cfg_wdata_i;
          CFG_MEASURE_NOISE: measure_noise_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (post_fire) begin
        unique case (step_q)
          ST_ANG: ang_q <= sat_w(sx(ang_q) + sx(mdu_res));
          ST_P0: begin
            p_q[0] <= sat_w(sx(p_q[0]) + sx(mdu_res));
            p_q[1] <= sat_w(sx(p_q[1]) - sx(t_q));
            p_q[2] <= sat_w(sx(p_q[2]) - sx(t_q));
          end
          ST_P3: p_q[3] <= sat_w(sx(p_q[3]) + sx(mdu_res));
          ST_CA: ang_q  <= sat_w(sx(ang_q) + sx(mdu_res));
          ST_CB: bias_q <= sat_w(sx(bias_q) + sx(mdu_res));
          ST_C0: p_q[0] <= sat_w(sx(p_q[0]) - sx(mdu_res));
          ST_C1: p_q[1] <= sat_w(sx(p_q[1]) - sx(mdu_res));
          ST_C2: p_q[2] <= sat_w(sx(p_q[2]) - sx(mdu_res));
          ST_C3: p_q[3] <= sat_w(sx(p_q[3]) - sx(mdu_res));
          default: ;
        endcase
      end
    end
  end

  // scratch values of one word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ma_q <= in_i.measured_angle;
      mr_q <= in_i.measured_rate;
      dt_q <= in_i.time_step;
    end
    if (post_fire) begin
      unique case (step_q)
        ST_T: begin
          t_q   <= mdu_res;
          inn_q <= sat_w(sx(mdu_res) - sx(p_q[1]));
        end
        ST_IN1: inn_q <= sat_w(sx(inn_q) - sx(p_q[2]));
        ST_IN2: inn_q <= sat_w(sx(inn_q) + zx_n(angle_noise_q));
        ST_P3:  s_q   <= sx(p_q[0]) + zx_n(measure_noise_q);
        ST_K0:  k0_q  <= mdu_res;
        ST_K1: begin
          k1_q <= mdu_res;
          y_q  <= sat_w(sx_in(ma_q) - sx(ang_q));
        end
        ST_CA: begin
          p00_q <= p_q[0];
          p01_q <= p_q[1];
        end
        ST_C3:  out_data_q <= sat_out(sx(ang_q));
        default: ;
      endcase
    end
  end

  assign in_i.ready           = (state_q == S_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.filtered_angle = out_data_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdu_done |-> (state_q == S_WAIT))
    else $error("unit finished outside of a wait");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_SETUP) && (step_q == ST_ANG))
    else $error("accepted word did not start the sequence");

  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(step_q) == ST_C3) && ($past(state_q) == S_POST))
    else $error("result word raised before the last correction");

endmodule
`default_nettype wire
